>>> rtl/core/assert_macros.svh
// Concurrent assertion helpers, clocked on clk, quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent in the same cycle
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds -> consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/ffha_pkg.sv
package ffha_pkg;

	localparam int FFHA_ARENA_BYTES  = 1024;
	localparam int FFHA_HEADER_BYTES = 16;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NO_SPACE = 2'd1;
	localparam logic [1:0] STAT_BAD_FREE = 2'd2;

	// one arena byte position: block start and in-use marks
	typedef struct packed {
		logic start;
		logic used;
	} mark_t;

endpackage

>>> rtl/core/first_fit_heap_allocator_top.sv
// First-fit heap allocator over a byte arena of ARENA_BYTES bytes, each block
// carrying a HEADER_BYTES header. One beat in gives one beat out. After reset
// the block runs a clearing pass over the whole mark memory, with in_stall
// high. The block takes one item at a time. An allocate walks the marks one
// byte per cycle from offset 0 until the first fitting block ends, then
// writes the split mark, if the block is larger than needed, and the in-use
// mark. A valid free walks forward to the next block start and back to the
// previous start, one byte per cycle, then clears the start mark of a free
// next block and marks its own start free, or clears it to join a free
// previous block. The single read port of the mark memory sets that pace. A
// finished result waits in the output register while the next beat is taken.
`include "assert_macros.svh"

module first_fit_heap_allocator_top
	import ffha_pkg::*;
#(
	parameter int ARENA_BYTES  = FFHA_ARENA_BYTES,
	parameter int HEADER_BYTES = FFHA_HEADER_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [9:0]  request_bytes,
	input  logic [9:0]  payload_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [9:0]  granted_address
);

	localparam int AW = $clog2(ARENA_BYTES);
	localparam int NW = (AW + 1 > 11) ? AW + 1 : 11;

	localparam logic [AW-1:0] LAST      = AW'(ARENA_BYTES - 1);
	localparam logic [NW-1:0] ARENA_N   = NW'(ARENA_BYTES);
	localparam logic [NW-1:0] HDR_N     = NW'(HEADER_BYTES);
	localparam logic [NW-1:0] PAY_LIM_N = NW'(1023 - HEADER_BYTES);

	localparam logic [3:0] ST_CLR    = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_AS     = 4'd2;
	localparam logic [3:0] ST_AEND   = 4'd3;
	localparam logic [3:0] ST_AW1    = 4'd4;
	localparam logic [3:0] ST_AW2    = 4'd5;
	localparam logic [3:0] ST_FCHK   = 4'd6;
	localparam logic [3:0] ST_FWD    = 4'd7;
	localparam logic [3:0] ST_BSTART = 4'd8;
	localparam logic [3:0] ST_BWD    = 4'd9;
	localparam logic [3:0] ST_FW1    = 4'd10;
	localparam logic [3:0] ST_FW2    = 4'd11;
	localparam logic [3:0] ST_DONE   = 4'd12;

	logic [3:0]    state_q;
	logic [AW-1:0] ptr_q;
	logic          vld_s1;
	logic [AW-1:0] idx_s1;
	mark_t         rd_s1;
	logic          out_valid_q;

	logic [AW-1:0] cur_s_q;
	logic          cur_use_q;
	logic [NW-1:0] blk_len_q;
	logic [NW-1:0] need_q;
	logic [AW-1:0] nxt_q;
	logic          nxt_free_q;
	logic          prv_free_q;
	logic          bad_q;
	logic [1:0]    res_status_q;
	logic [9:0]    res_addr_q;
	logic [1:0]    status_q;
	logic [9:0]    granted_q;

	mark_t mem [ARENA_BYTES];

	logic          accept;
	logic          scan_st;
	logic          fit;
	logic          out_load;
	logic [NW-1:0] free_s_n;
	logic          bad_rng;
	logic          we;
	logic [AW-1:0] waddr;
	mark_t         wdata;
	logic [AW-1:0] raddr;

	assign in_stall        = (state_q != ST_IDLE);
	assign accept          = in_valid && !in_stall;
	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign granted_address = granted_q;

	assign scan_st  = state_q inside {ST_AS, ST_FWD, ST_BWD};
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	assign free_s_n = NW'(payload_address) - HDR_N;
	assign bad_rng  = (NW'(payload_address) < HDR_N) || (free_s_n >= ARENA_N);

	assign fit = !cur_use_q && (blk_len_q >= need_q) && (NW'(cur_s_q) <= PAY_LIM_N);

	assign raddr = (state_q == ST_IDLE) ? AW'(free_s_n) : ptr_q;

	always_comb begin
		we    = 1'b0;
		waddr = ptr_q;
		wdata = '0;
		case (state_q)
			ST_CLR: begin
				we          = 1'b1;
				wdata.start = (ptr_q == '0);
			end
			ST_AW1: begin
				we    = (blk_len_q > need_q);
				waddr = AW'(NW'(cur_s_q) + need_q);
				wdata = '{start: 1'b1, used: 1'b0};
			end
			ST_AW2: begin
				we    = 1'b1;
				waddr = cur_s_q;
				wdata = '{start: 1'b1, used: 1'b1};
			end
			ST_FW1: begin
				we    = nxt_free_q;
				waddr = nxt_q;
			end
			ST_FW2: begin
				we    = 1'b1;
				waddr = cur_s_q;
				wdata = prv_free_q ? mark_t'('0) : mark_t'{start: 1'b1, used: 1'b0};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_s1  <= mem[raddr];
		idx_s1 <= ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			ptr_q       <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= scan_st;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					ptr_q <= ptr_q + AW'(1);
					if (ptr_q == LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					ptr_q <= '0;
					if (accept) begin
						state_q <= (op == OP_ALLOC) ? ST_AS : ST_FCHK;
					end
				end
				ST_AS: begin
					ptr_q <= ptr_q + AW'(1);
					if (vld_s1) begin
						if (idx_s1 != '0 && rd_s1.start && fit) begin
							state_q <= ST_AW1;
						end else if (idx_s1 == LAST) begin
							state_q <= ST_AEND;
						end
					end
				end
				ST_AEND: begin
					state_q <= fit ? ST_AW1 : ST_DONE;
				end
				ST_AW1: begin
					state_q <= ST_AW2;
				end
				ST_AW2: begin
					state_q <= ST_DONE;
				end
				ST_FCHK: begin
					ptr_q <= cur_s_q + AW'(1);
					if (bad_q || !rd_s1.start || !rd_s1.used) begin
						state_q <= ST_DONE;
					end else if (cur_s_q == LAST) begin
						state_q <= ST_BSTART;
					end else begin
						state_q <= ST_FWD;
					end
				end
				ST_FWD: begin
					ptr_q <= ptr_q + AW'(1);
					if (vld_s1 && (rd_s1.start || idx_s1 == LAST)) begin
						state_q <= ST_BSTART;
					end
				end
				ST_BSTART: begin
					ptr_q   <= cur_s_q - AW'(1);
					state_q <= (cur_s_q == '0) ? ST_FW1 : ST_BWD;
				end
				ST_BWD: begin
					// offset 0 is always a block start, so the walk ends there
					ptr_q <= ptr_q - AW'(1);
					if (vld_s1 && rd_s1.start) begin
						state_q <= ST_FW1;
					end
				end
				ST_FW1: begin
					state_q <= ST_FW2;
				end
				ST_FW2: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers of the current item
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					need_q  <= NW'(request_bytes) + HDR_N;
					cur_s_q <= AW'(free_s_n);
					bad_q   <= bad_rng;
				end
			end
			ST_AS: begin
				if (vld_s1 && !(idx_s1 != '0 && rd_s1.start && fit)) begin
					if (rd_s1.start) begin
						cur_s_q   <= idx_s1;
						cur_use_q <= rd_s1.used;
						blk_len_q <= NW'(1);
					end else begin
						blk_len_q <= blk_len_q + NW'(1);
					end
				end
			end
			ST_AEND: begin
				if (!fit) begin
					res_status_q <= STAT_NO_SPACE;
					res_addr_q   <= '0;
				end
			end
			ST_AW2: begin
				res_status_q <= STAT_OK;
				res_addr_q   <= 10'(NW'(cur_s_q) + HDR_N);
			end
			ST_FCHK: begin
				nxt_free_q   <= 1'b0;
				res_status_q <= STAT_BAD_FREE;
				res_addr_q   <= '0;
			end
			ST_FWD: begin
				if (vld_s1 && rd_s1.start) begin
					nxt_q      <= idx_s1;
					nxt_free_q <= !rd_s1.used;
				end
			end
			ST_BSTART: begin
				prv_free_q <= 1'b0;
			end
			ST_BWD: begin
				if (vld_s1 && rd_s1.start) begin
					prv_free_q <= !rd_s1.used;
				end
			end
			ST_FW2: begin
				res_status_q <= STAT_OK;
				res_addr_q   <= '0;
			end
			default: begin
				res_status_q <= res_status_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q  <= res_status_q;
			granted_q <= res_addr_q;
		end
	end

	`ASSERT_SAME(a_addr_only_on_grant, out_valid && status != STAT_OK, granted_address == '0, "address on a failed beat")
	`ASSERT_SAME(a_split_in_arena, state_q == ST_AW1 && blk_len_q > need_q, NW'(cur_s_q) + need_q < ARENA_N, "split point outside arena")
	`ASSERT_SAME(a_clear_stalls, state_q == ST_CLR, in_stall, "input taken during clearing pass")
	`ASSERT_NEXT(a_result_from_done, !out_valid_q, !out_valid_q || $past(state_q) == ST_DONE, "result loaded outside done")

endmodule
